// ===== design/gni_pkg.sv =====
// Shared types, constants and helpers of the grid neighbor index generator.
`default_nettype none
package gni_pkg;

	localparam int MAX_SIDE = 1024;
	localparam int SIDE_W   = $clog2(MAX_SIDE) + 1;
	localparam int COORD_W  = $clog2(MAX_SIDE);
	localparam int IDX_W    = 2 * COORD_W;
	localparam int Q_DEPTH  = 2;
	localparam int Q_PTR_W  = $clog2(Q_DEPTH);
	localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

	// Neighbor directions
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_WIDTH    = 2'd0;
	localparam logic [1:0] CFG_HEIGHT   = 2'd1;
	localparam logic [1:0] CFG_TOPOLOGY = 2'd2;

	localparam logic [SIDE_W-1:0] MIN_SIDE_V = SIDE_W'(3);
	localparam logic [SIDE_W-1:0] MAX_SIDE_V = SIDE_W'(MAX_SIDE);

	typedef struct packed {
		logic [SIDE_W-1:0] width;
		logic [SIDE_W-1:0] height;
		logic              vwrap;
		logic              hwrap;
	} cfg_t;

	// One classified cell waiting for the back end
	typedef struct packed {
		logic                  oor;
		logic [1:0]            last_k;
		logic [3:0][1:0]       dirs;
		logic [COORD_W-1:0]    x;
		logic [IDX_W-1:0]      row;
		logic                  bot;
		logic                  top;
		logic                  lft;
		logic                  rgt;
	} q_entry_t;

	function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
		logic [SIDE_W-1:0] r;
		if (v < MIN_SIDE_V) begin
			r = MIN_SIDE_V;
		end else if (v > MAX_SIDE_V) begin
			r = MAX_SIDE_V;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/gni_cell_if.sv =====
// Input channel carrying one cell coordinate per item.
`default_nettype none
interface gni_cell_if import gni_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] cell_x;
	logic [COORD_W-1:0] cell_y;

	modport source(output valid, cell_x, cell_y, input ready);
	modport sink(input valid, cell_x, cell_y, output ready);
endinterface
`default_nettype wire

// ===== design/gni_nbr_if.sv =====
// Output channel carrying one neighbor index per item.
`default_nettype none
interface gni_nbr_if import gni_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] neighbor_index;
	logic [1:0]       direction;
	logic             last;
	logic             out_of_range;

	modport source(output valid, neighbor_index, direction, last, out_of_range, input ready);
	modport sink(input valid, neighbor_index, direction, last, out_of_range, output ready);
endinterface
`default_nettype wire

// ===== design/gni_front.sv =====
// Front end: accepts cells, classifies them and forms the row base.
`default_nettype none
module gni_front import gni_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	gni_cell_if.sink    coord,
	output q_entry_t    entry,
	output logic        push,
	input  wire logic   q_ready
);

	logic               valid_s1;
	logic [COORD_W-1:0] x_s1;
	logic [COORD_W-1:0] y_s1;
	logic [IDX_W-1:0]   prod;
	logic               bot, top, lft, rgt, row_edge, col_edge;
	logic [1:0]         vdir, hdir;

	assign coord.ready = !valid_s1 || q_ready;
	assign push        = valid_s1;

	// Hold the accepted cell until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (coord.valid && coord.ready) begin
			valid_s1 <= 1'b1;
		end else if (q_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (coord.valid && coord.ready) begin
			x_s1 <= coord.cell_x;
			y_s1 <= coord.cell_y;
		end
	end

	// Row base y * width
	assign prod = IDX_W'(y_s1) * IDX_W'(cfg.width);

	// Classify the cell and pick its direction order
	always_comb begin
		bot      = (y_s1 == '0);
		top      = ({1'b0, y_s1} == cfg.height - SIDE_W'(1));
		lft      = (x_s1 == '0);
		rgt      = ({1'b0, x_s1} == cfg.width - SIDE_W'(1));
		row_edge = bot || top;
		col_edge = lft || rgt;
		vdir     = bot ? DIR_DOWN : DIR_UP;
		hdir     = lft ? DIR_LEFT : DIR_RIGHT;

		entry        = '0;
		entry.x      = x_s1;
		entry.row    = prod;
		entry.bot    = bot;
		entry.top    = top;
		entry.lft    = lft;
		entry.rgt    = rgt;
		entry.oor    = ({1'b0, x_s1} >= cfg.width) || ({1'b0, y_s1} >= cfg.height);

		if (entry.oor) begin
			entry.last_k  = 2'd0;
			entry.dirs[0] = DIR_UP;
		end else if (row_edge && col_edge) begin
			entry.dirs[0] = lft ? DIR_RIGHT : DIR_LEFT;
			entry.dirs[1] = bot ? DIR_UP : DIR_DOWN;
			entry.dirs[2] = cfg.vwrap ? vdir : hdir;
			entry.dirs[3] = hdir;
			entry.last_k  = 2'd1 + {1'b0, cfg.vwrap} + {1'b0, cfg.hwrap};
		end else if ((row_edge && !cfg.vwrap) || (col_edge && !cfg.hwrap)) begin
			entry.last_k = 2'd2;
			if (bot) begin
				entry.dirs[0] = DIR_UP;
				entry.dirs[1] = DIR_LEFT;
				entry.dirs[2] = DIR_RIGHT;
			end else if (top) begin
				entry.dirs[0] = DIR_DOWN;
				entry.dirs[1] = DIR_LEFT;
				entry.dirs[2] = DIR_RIGHT;
			end else if (lft) begin
				entry.dirs[0] = DIR_UP;
				entry.dirs[1] = DIR_DOWN;
				entry.dirs[2] = DIR_RIGHT;
			end else begin
				entry.dirs[0] = DIR_DOWN;
				entry.dirs[1] = DIR_UP;
				entry.dirs[2] = DIR_LEFT;
			end
		end else begin
			entry.last_k  = 2'd3;
			entry.dirs[0] = DIR_UP;
			entry.dirs[1] = DIR_DOWN;
			entry.dirs[2] = DIR_RIGHT;
			entry.dirs[3] = DIR_LEFT;
		end
	end

endmodule
`default_nettype wire

// ===== design/gni_queue.sv =====
// Short queue of classified cells between front and back end.
`default_nettype none
module gni_queue import gni_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire q_entry_t wr_entry,
	input  wire logic     push,
	output logic          q_ready,
	output q_entry_t      head,
	output logic          head_valid,
	input  wire logic     pop
);

	q_entry_t             mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;
	logic                 do_push, do_pop;

	assign q_ready    = (cnt_q != Q_CNT_W'(Q_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && q_ready;
	assign do_pop     = pop && head_valid;

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + Q_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + Q_PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + Q_CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - Q_CNT_W'(1);
			end
		end
	end

	// Store the entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule
`default_nettype wire

// ===== design/gni_back.sv =====
// Back end: walks a cell's directions and emits one neighbor index per cycle while the output is ready.
`default_nettype none
module gni_back import gni_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire cfg_t     cfg,
	input  wire q_entry_t head,
	input  wire logic     head_valid,
	output logic          pop,
	gni_nbr_if.source     nbr
);

	logic [1:0]            k_q;
	logic                  valid_q;
	logic [IDX_W-1:0]      idx_q;
	logic [1:0]            dir_q;
	logic                  last_q;
	logic                  oor_q;
	logic [IDX_W-1:0]      wrap_base_q;
	logic [IDX_W-1:0]      wb_prod;
	logic [IDX_W-1:0]      w20, x20, base, idx;
	logic [1:0]            dir;
	logic                  last_now, load;

	assign nbr.valid          = valid_q;
	assign nbr.neighbor_index = idx_q;
	assign nbr.direction      = dir_q;
	assign nbr.last           = last_q;
	assign nbr.out_of_range   = oor_q;

	// Base of the top row for the vertical wrap
	assign wb_prod = IDX_W'(cfg.height - SIDE_W'(1)) * IDX_W'(cfg.width);

	always_ff @(posedge clk) begin
		wrap_base_q <= wb_prod;
	end

	assign dir      = head.dirs[k_q];
	assign last_now = head.oor || (k_q == head.last_k);
	assign load     = head_valid && (!valid_q || nbr.ready);
	assign pop      = load && last_now;

	// Form the neighbor index for the current direction
	always_comb begin
		w20  = IDX_W'(cfg.width);
		x20  = IDX_W'(head.x);
		base = head.row + x20;
		case (dir)
			DIR_UP:    idx = head.top ? x20 : base + w20;
			DIR_DOWN:  idx = head.bot ? x20 + wrap_base_q : base - w20;
			DIR_RIGHT: idx = head.rgt ? head.row : base + IDX_W'(1);
			default:   idx = head.lft ? head.row + w20 - IDX_W'(1) : base - IDX_W'(1);
		endcase
		if (head.oor) begin
			idx = '0;
		end
	end

	// Advance through the cell's directions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			k_q     <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				k_q     <= last_now ? 2'd0 : k_q + 2'd1;
			end else if (nbr.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			idx_q  <= idx;
			dir_q  <= dir;
			last_q <= last_now;
			oor_q  <= head.oor;
		end
	end

endmodule
`default_nettype wire

// ===== design/grid_neighbor_index_generator.sv =====
// Top level: configuration registers, front end, queue and back end.
// Path: the cell is registered in the front end, stored in the queue, and its first neighbor
// is registered at the back end output. The back end emits one neighbor per cycle while the
// output is ready; a cell gives 2 to 4 neighbors (one item for a coordinate outside the grid).
// A cell can be accepted every cycle while the two-entry queue has room.
// Reset: width and height 3, no wrap, queue and output empty.
`default_nettype none
module grid_neighbor_index_generator import gni_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [SIDE_W-1:0] cfg_data,
	gni_cell_if.sink               coord,
	gni_nbr_if.source              nbr
);

	logic [SIDE_W-1:0] width_q;
	logic [SIDE_W-1:0] height_q;
	logic [1:0]        topo_q;
	cfg_t              cfg;
	q_entry_t          entry, head;
	logic              push, q_ready, head_valid, pop;

	// Write configuration registers, clamping the grid sides
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= MIN_SIDE_V;
			height_q <= MIN_SIDE_V;
			topo_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH:    width_q  <= clamp_side(cfg_data);
				CFG_HEIGHT:   height_q <= clamp_side(cfg_data);
				CFG_TOPOLOGY: topo_q   <= cfg_data[1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		cfg.width  = width_q;
		cfg.height = height_q;
		cfg.vwrap  = topo_q[0];
		cfg.hwrap  = topo_q[1];
	end

	gni_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.coord   (coord),
		.entry   (entry),
		.push    (push),
		.q_ready (q_ready)
	);

	gni_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_entry   (entry),
		.push       (push),
		.q_ready    (q_ready),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop)
	);

	gni_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.nbr        (nbr)
	);

endmodule
`default_nettype wire
